// ===== sv/dvfs_volt_interpolate_lookup_top_assert.svh =====
// Assertion helpers for the checker file.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef DVFS_VOLT_INTERPOLATE_LOOKUP_TOP_ASSERT_SVH
`define DVFS_VOLT_INTERPOLATE_LOOKUP_TOP_ASSERT_SVH

// Same-cycle implication.
`define DVIL_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dvil assertion failed");

// Next-cycle implication.
`define DVIL_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dvil assertion failed");

`endif

// ===== sv/dvil_pkg.sv =====
package dvil_pkg;

	// table geometry
	localparam int MAX_LEVELS_DEF = 32;
	localparam int RATE_W         = 24;
	localparam int VOLT_W         = 10;
	localparam int UV_W           = 23;
	localparam int CNT_W          = 6;
	localparam int IDX_W          = 5;
	localparam int ENTRY_W        = RATE_W + VOLT_W;

	localparam logic [UV_W-1:0]   STEP_UV        = UV_W'(6250);
	localparam logic [RATE_W-1:0] LOW_RATE_GUARD = RATE_W'(32'h100);

	// result status codes
	typedef enum logic [2:0] {
		ST_MATCH      = 3'd0,
		ST_CLAMP_HIGH = 3'd1,
		ST_CLAMP_LOW  = 3'd2,
		ST_PRIOR      = 3'd3,
		ST_FAULT      = 3'd4,
		ST_WRITE      = 3'd5
	} status_t;

	// request to the serial divider
	typedef struct packed {
		logic              start;
		logic [RATE_W-1:0] dividend;
		logic [RATE_W-1:0] divisor;
	} div_req_t;

	// volt steps to microvolts
	function automatic logic [UV_W-1:0] to_uv(input logic [VOLT_W-1:0] v);
		to_uv = UV_W'(v) * STEP_UV;
	endfunction

endpackage

// ===== sv/dvil_ram.sv =====
module dvil_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/dvil_div.sv =====
module dvil_div import dvil_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	output logic              done,
	output logic [RATE_W-1:0] quo
);

	localparam int DCW = $clog2(RATE_W + 1);

	logic              active_q;
	logic              done_q;
	logic [DCW-1:0]    cnt_q;
	logic [RATE_W-1:0] rem_q;
	logic [RATE_W-1:0] quo_q;
	logic [RATE_W-1:0] dvs_q;

	logic [RATE_W:0]   rem_sh;
	logic [RATE_W:0]   rem_sub;
	logic              bit_c;

	// one restoring step per cycle
	always_comb begin
		rem_sh  = {rem_q, quo_q[RATE_W-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		bit_c   = (rem_sh >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				active_q <= 1'b1;
				cnt_q    <= DCW'(RATE_W);
			end else if (active_q) begin
				cnt_q <= cnt_q - DCW'(1);
				if (cnt_q == DCW'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (active_q) begin
			rem_q <= bit_c ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
			quo_q <= {quo_q[RATE_W-2:0], bit_c};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== sv/dvfs_volt_interpolate_lookup_top.sv =====
// Piecewise linear voltage lookup over a stored rate/voltage table.
// Requests enter on start while busy is low; cmd selects a level write (0)
// or a rate query (1). Each request gives exactly one result, shown for one
// cycle with done high, on volt_uv, status and result_last.
// The level count register is written on cfg_valid & cfg_ready; cfg_ready
// is high whenever the block is not busy.
// A write answers in the next cycle and keeps busy low.
// A query walks the stored levels one per cycle through the table RAM read
// port, then runs up to two 24-step serial divisions on the shared divider,
// then up to two RAM reads for clamping; busy stays high throughout. The
// result appears in the cycle busy falls, and no new request is taken
// while a query runs.
// Reset clears the level count and the sequencer; table contents stay
// undefined until written. Results cannot be stalled by the receiver.
module dvfs_volt_interpolate_lookup_top import dvil_pkg::*; #(
	parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              cmd,
	input  logic [IDX_W-1:0]  level_index,
	input  logic [RATE_W-1:0] level_rate_khz,
	input  logic [VOLT_W-1:0] level_volt_steps,
	input  logic [RATE_W-1:0] query_rate_khz,
	input  logic [UV_W-1:0]   prior_volt_uv,
	input  logic              query_last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data,
	output logic              done,
	output logic [UV_W-1:0]   volt_uv,
	output logic [2:0]        status,
	output logic              result_last
);

	localparam int AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int CW = $clog2(MAX_LEVELS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_FIRST, S_WALK, S_PAIR, S_DIV1, S_DIV2, S_ZCHK, S_CL0, S_CL1
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  level_count_q;
	logic [CW-1:0]     n_q;
	logic [AW-1:0]     j_q;
	logic [RATE_W-1:0] rate_q;
	logic [UV_W-1:0]   volt_q;
	logic              matched_q;
	logic              last_q;
	logic [ENTRY_W-1:0] up_q;
	logic [ENTRY_W-1:0] dn_q;

	logic              done_q;
	logic [UV_W-1:0]   volt_uv_q;
	status_t           status_q;
	logic              result_last_q;

	logic               accept;
	logic               ram_we;
	logic [AW-1:0]      rd_addr_c;
	logic [ENTRY_W-1:0] rd_data;
	logic [CW-1:0]      n_c;
	div_req_t           div_req;
	logic               div_done;
	logic [RATE_W-1:0]  div_quo;

	logic [RATE_W-1:0] up_rate, dn_rate, rd_rate;
	logic [VOLT_W-1:0] up_volt, dn_volt, rd_volt;
	logic [VOLT_W-1:0] span_c;
	logic [VOLT_W-1:0] steps_c;
	logic              brackets_c;
	status_t           base_st;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign ram_we    = accept && !cmd && (int'(level_index) < MAX_LEVELS);

	assign up_rate = up_q[ENTRY_W-1:VOLT_W];
	assign up_volt = up_q[VOLT_W-1:0];
	assign dn_rate = dn_q[ENTRY_W-1:VOLT_W];
	assign dn_volt = dn_q[VOLT_W-1:0];
	assign rd_rate = rd_data[ENTRY_W-1:VOLT_W];
	assign rd_volt = rd_data[VOLT_W-1:0];

	// effective level count
	assign n_c = (int'(level_count_q) > MAX_LEVELS) ? CW'(MAX_LEVELS) : CW'(level_count_q);

	// table storage: rate and volt side by side
	dvil_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_LEVELS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(level_index)),
		.wdata({level_rate_khz, level_volt_steps}),
		.raddr(rd_addr_c),
		.rdata(rd_data)
	);

	dvil_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.done  (div_done),
		.quo   (div_quo)
	);

	// read address, divider request, pair decode
	always_comb begin
		rd_addr_c        = '0;
		span_c           = up_volt - dn_volt;
		div_req.start    = 1'b0;
		div_req.dividend = up_rate - dn_rate;
		div_req.divisor  = RATE_W'(span_c);
		brackets_c       = (rate_q <= up_rate) && (rate_q >= rd_rate);
		steps_c          = (div_quo > RATE_W'(up_volt)) ? '0 : (up_volt - div_quo[VOLT_W-1:0]);
		base_st          = matched_q ? ST_MATCH : ST_PRIOR;
		case (state_q)
			S_FIRST: rd_addr_c = AW'(1);
			S_WALK:  rd_addr_c = j_q + AW'(1);
			S_CL0:   rd_addr_c = AW'(n_q - CW'(1));
			S_PAIR: begin
				div_req.start = (up_rate >= LOW_RATE_GUARD) && (dn_rate != '0) &&
					(up_rate != dn_rate) && (up_volt > dn_volt);
			end
			S_DIV1: begin
				div_req.start    = div_done && (div_quo != '0);
				div_req.dividend = up_rate - rate_q;
				div_req.divisor  = div_quo;
			end
			default: rd_addr_c = '0;
		endcase
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			level_count_q <= '0;
			n_q           <= '0;
			j_q           <= '0;
			rate_q        <= '0;
			volt_q        <= '0;
			matched_q     <= 1'b0;
			last_q        <= 1'b0;
			up_q          <= '0;
			dn_q          <= '0;
			done_q        <= 1'b0;
			volt_uv_q     <= '0;
			status_q      <= ST_MATCH;
			result_last_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				level_count_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!cmd) begin
							done_q        <= 1'b1;
							volt_uv_q     <= '0;
							status_q      <= ST_WRITE;
							result_last_q <= 1'b0;
						end else begin
							n_q       <= n_c;
							rate_q    <= query_rate_khz;
							volt_q    <= prior_volt_uv;
							last_q    <= query_last;
							matched_q <= 1'b0;
							state_q   <= (n_c < CW'(2)) ? S_ZCHK : S_FIRST;
						end
					end
				end
				S_FIRST: begin
					up_q    <= rd_data;
					j_q     <= AW'(1);
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (brackets_c) begin
						dn_q      <= rd_data;
						matched_q <= 1'b1;
						state_q   <= S_PAIR;
					end else if (int'(j_q) == int'(n_q) - 1) begin
						state_q <= S_ZCHK;
					end else begin
						up_q <= rd_data;
						j_q  <= j_q + AW'(1);
					end
				end
				S_PAIR: begin
					if (up_rate < LOW_RATE_GUARD) begin
						volt_q  <= to_uv(dn_volt);
						state_q <= S_ZCHK;
					end else if ((dn_rate == '0) || (up_rate == dn_rate) ||
						(up_volt == dn_volt)) begin
						volt_q  <= to_uv(up_volt);
						state_q <= S_ZCHK;
					end else if (up_volt < dn_volt) begin
						done_q        <= 1'b1;
						volt_uv_q     <= '0;
						status_q      <= ST_FAULT;
						result_last_q <= last_q;
						state_q       <= S_IDLE;
					end else begin
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						if (div_quo == '0) begin
							done_q        <= 1'b1;
							volt_uv_q     <= '0;
							status_q      <= ST_FAULT;
							result_last_q <= last_q;
							state_q       <= S_IDLE;
						end else begin
							state_q <= S_DIV2;
						end
					end
				end
				S_DIV2: begin
					if (div_done) begin
						volt_q  <= to_uv(steps_c);
						state_q <= S_ZCHK;
					end
				end
				S_ZCHK: begin
					if ((volt_q == '0) && (n_q != '0)) begin
						state_q <= S_CL0;
					end else begin
						done_q        <= 1'b1;
						volt_uv_q     <= volt_q;
						status_q      <= base_st;
						result_last_q <= last_q;
						state_q       <= S_IDLE;
					end
				end
				S_CL0: begin
					if (rate_q > rd_rate) begin
						done_q        <= 1'b1;
						volt_uv_q     <= to_uv(rd_volt);
						status_q      <= ST_CLAMP_HIGH;
						result_last_q <= last_q;
						state_q       <= S_IDLE;
					end else begin
						state_q <= S_CL1;
					end
				end
				S_CL1: begin
					done_q        <= 1'b1;
					result_last_q <= last_q;
					state_q       <= S_IDLE;
					if (rate_q < rd_rate) begin
						volt_uv_q <= to_uv(rd_volt);
						status_q  <= ST_CLAMP_LOW;
					end else begin
						volt_uv_q <= volt_q;
						status_q  <= base_st;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done        = done_q;
	assign volt_uv     = volt_uv_q;
	assign status      = status_q;
	assign result_last = result_last_q;

endmodule

// ===== sv/dvil_checker.sv =====
`include "dvfs_volt_interpolate_lookup_top_assert.svh"

module dvil_checker import dvil_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              cmd,
	input logic              cfg_ready,
	input logic              done,
	input logic [UV_W-1:0]   volt_uv,
	input logic [2:0]        status,
	input logic              result_last
);

	// a write request answers in the next cycle, with no last flag
	`DVIL_ASSERT_NXT(a_write_next, start && !busy && !cmd, done && (status == ST_WRITE) && !result_last)

	// a query request holds the block busy
	`DVIL_ASSERT_NXT(a_query_busy, start && !busy && cmd, busy && !done)

	// the query result shows as busy drops
	`DVIL_ASSERT_IMP(a_fall_done, $fell(busy), done && (status != ST_WRITE))

	// write and fault results carry zero voltage
	`DVIL_ASSERT_IMP(a_zero_volt, done && ((status == ST_WRITE) || (status == ST_FAULT)),
		volt_uv == '0)

	// configuration is refused while a query runs
	`DVIL_ASSERT_IMP(a_cfg_idle, busy, !cfg_ready)

endmodule

bind dvfs_volt_interpolate_lookup_top dvil_checker u_dvil_checker (.*);
